// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used by the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define MBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also checks through reset
`define MBS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker step package
// Payload types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mbs_pkg;

  // Default grid limit and fixed field widths
  localparam int DEF_MAX_SIDE = 32;
  localparam int RESET_SIDE   = 32;
  localparam int COORD_W      = 5;
  localparam int RAND_W       = 16;
  localparam int CFG_W        = 6;
  localparam int WALL_W       = 4;
  localparam int CELL_W       = WALL_W + 1;   // visited bit above the walls

  localparam logic [WALL_W-1:0] WALLS_ALL = '1;

  typedef enum logic [1:0] {
    OP_CARVE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_IGNORE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_CARVED   = 2'd0,
    KIND_BACK     = 2'd1,
    KIND_FINISHED = 2'd2,
    KIND_REPLY    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // Input transaction
  typedef struct packed {
    logic [1:0]         operation;
    logic [RAND_W-1:0]  random_value;
    logic [COORD_W-1:0] query_col;
    logic [COORD_W-1:0] query_row;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic [1:0]         step_kind;
    logic [1:0]         carve_direction;
    logic [WALL_W-1:0]  cell_walls;
  } out_item_t;

  // Datapath action for one cycle
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_CLR_INIT,
    ACT_CLR_STEP,
    ACT_ACCEPT,
    ACT_RD_CUR,
    ACT_RD_UP,
    ACT_RD_RIGHT,
    ACT_RD_DOWN,
    ACT_RD_LEFT,
    ACT_RD_QUERY,
    ACT_DECIDE,
    ACT_WR_NEXT,
    ACT_POP,
    ACT_PUBLISH
  } act_t;

  // Source of the reported walls
  typedef enum logic [1:0] {
    WSEL_RD,
    WSEL_CUR,
    WSEL_NEXT,
    WSEL_ALL
  } wsel_t;

  // Source of the reported cell position
  typedef enum logic [1:0] {
    LSEL_CUR,
    LSEL_QUERY,
    LSEL_ORIGIN
  } lsel_t;

  typedef struct packed {
    kind_t kind;
    wsel_t wsel;
    lsel_t lsel;
  } reply_t;

  typedef struct packed {
    act_t   act;
    reply_t rep;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       finished;
    logic       q_in_grid;
    logic       has_cand;
    logic       stack_empty;
    logic       clear_last;
    logic       out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_CLR_INIT,
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RD_REPLY,
    S_RD_QUERY,
    S_CV_CUR,
    S_CV_UP,
    S_CV_RIGHT,
    S_CV_DOWN,
    S_CV_LEFT,
    S_DECIDE,
    S_WR_NEXT,
    S_POP,
    S_REPLY
  } state_t;

endpackage

// ===== sv/maze_backtracker_step_unit.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker step unit
// Depth-first maze carving with an explicit stack, one step per transaction.
// ----------------------------------------------------------------------------
//  channel | signals                         | transfer
//  --------+---------------------------------+---------------------------
//  input   | in_valid in_ready in_data       | valid and ready high
//  result  | out_valid out_ready out_data    | valid and ready high
//  config  | cfg_we cfg_wdata                | cfg_we high, no wait
//
// A read outside the grid replies without a memory read, a read in the grid
// reads the queried cell, ignored ops and carves after finishing read the
// current cell, and a carve, backtrack or finish also reads the neighbours.
// A restart reruns the clear. Carve time is set by five reads through the
// single memory port. Reset and an idle grid_side write clear cells first.
// A held result lets the next transaction in but stalls its reply.
// ----------------------------------------------------------------------------
module maze_backtracker_step_unit import mbs_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  mbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Memories and registers
  mbs_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/mbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker step controller
// Sequences clearing, memory reads, carve decision, pop and reply publish.
// ----------------------------------------------------------------------------
module mbs_ctrl import mbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     cfg_we,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  reply_t rep_r, rep_nxt;
  logic   restart_r, restart_nxt;
  act_t   act;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR_INIT;
      rep_r     <= '{kind: KIND_REPLY, wsel: WSEL_ALL, lsel: LSEL_ORIGIN};
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rep_r     <= rep_nxt;
      restart_r <= restart_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    rep_nxt     = rep_r;
    restart_nxt = restart_r;
    act         = ACT_NOP;
    in_ready    = 1'b0;
    unique case (state_r)
      S_CLR_INIT: begin
        act       = ACT_CLR_INIT;
        state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        if (cfg_we) begin
          // new grid size mid-sweep: start the sweep again
          act = ACT_CLR_INIT;
        end else begin
          act = ACT_CLR_STEP;
          if (stat.clear_last) begin
            if (restart_r) begin
              restart_nxt = 1'b0;
              rep_nxt     = '{kind: KIND_REPLY, wsel: WSEL_ALL, lsel: LSEL_ORIGIN};
              state_nxt   = S_REPLY;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_IDLE: begin
        in_ready = !cfg_we;
        if (cfg_we) begin
          state_nxt = S_CLR_INIT;
        end else if (in_valid) begin
          act       = ACT_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_CARVE: begin
            if (stat.finished) begin
              rep_nxt   = '{kind: KIND_FINISHED, wsel: WSEL_RD, lsel: LSEL_CUR};
              state_nxt = S_RD_REPLY;
            end else begin
              state_nxt = S_CV_CUR;
            end
          end
          OP_READ: begin
            if (stat.q_in_grid) begin
              rep_nxt   = '{kind: KIND_REPLY, wsel: WSEL_RD, lsel: LSEL_QUERY};
              state_nxt = S_RD_QUERY;
            end else begin
              rep_nxt   = '{kind: KIND_REPLY, wsel: WSEL_ALL, lsel: LSEL_QUERY};
              state_nxt = S_REPLY;
            end
          end
          OP_RESTART: begin
            restart_nxt = 1'b1;
            state_nxt   = S_CLR_INIT;
          end
          default: begin
            rep_nxt   = '{kind: KIND_REPLY, wsel: WSEL_RD, lsel: LSEL_CUR};
            state_nxt = S_RD_REPLY;
          end
        endcase
      end
      S_RD_REPLY: begin
        act       = ACT_RD_CUR;
        state_nxt = S_REPLY;
      end
      S_RD_QUERY: begin
        act       = ACT_RD_QUERY;
        state_nxt = S_REPLY;
      end
      // one memory read per cycle: current cell then the four neighbours
      S_CV_CUR: begin
        act       = ACT_RD_CUR;
        state_nxt = S_CV_UP;
      end
      S_CV_UP: begin
        act       = ACT_RD_UP;
        state_nxt = S_CV_RIGHT;
      end
      S_CV_RIGHT: begin
        act       = ACT_RD_RIGHT;
        state_nxt = S_CV_DOWN;
      end
      S_CV_DOWN: begin
        act       = ACT_RD_DOWN;
        state_nxt = S_CV_LEFT;
      end
      S_CV_LEFT: begin
        act       = ACT_RD_LEFT;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        act = ACT_DECIDE;
        if (stat.has_cand) begin
          rep_nxt   = '{kind: KIND_CARVED, wsel: WSEL_NEXT, lsel: LSEL_CUR};
          state_nxt = S_WR_NEXT;
        end else if (!stat.stack_empty) begin
          rep_nxt   = '{kind: KIND_BACK, wsel: WSEL_RD, lsel: LSEL_CUR};
          state_nxt = S_POP;
        end else begin
          rep_nxt   = '{kind: KIND_FINISHED, wsel: WSEL_CUR, lsel: LSEL_CUR};
          state_nxt = S_REPLY;
        end
      end
      S_WR_NEXT: begin
        act       = ACT_WR_NEXT;
        state_nxt = S_REPLY;
      end
      S_POP: begin
        act       = ACT_POP;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (stat.out_free) begin
          act       = ACT_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR_INIT;
      end
    endcase
  end

  assign cmd.act = act;
  assign cmd.rep = rep_r;

endmodule

// ===== sv/mbs_dpath.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker step datapath
// Cell memory (visited + walls), path stack, position, depth and result reg.
// ----------------------------------------------------------------------------
module mbs_dpath import mbs_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int CW         = $clog2(MAX_SIDE);
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int DW         = $clog2(CELL_COUNT + 1);
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int SIDE_RST   = (MAX_SIDE < RESET_SIDE) ? MAX_SIDE : RESET_SIDE;

  // Row-major cell index
  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
    return AW'(r * MAX_SIDE + c);
  endfunction

  // Grid side saturated to 2..MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    if (v < CFG_W'(2)) begin
      return SIDE_W'(2);
    end else if (32'(v) > MAX_SIDE) begin
      return SIDE_W'(MAX_SIDE);
    end
    return SIDE_W'(v);
  endfunction

  // 16-bit residue mod 3 by folding base-4 digits (4 = 1 mod 3)
  function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < RAND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

  // Memories
  logic [CELL_W-1:0] cell_mem  [CELL_COUNT];
  logic [2*CW-1:0]   stack_mem [CELL_COUNT];

  // Control registers
  logic [SIDE_W-1:0] side_r;
  act_t              act_q_r;
  logic [CW-1:0]     cur_row_r, cur_col_r;
  logic [DW-1:0]     depth_r;
  logic              finished_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              out_valid_r;

  // Payload registers
  in_item_t          req_r;
  logic [1:0]        mod3_r;
  logic [WALL_W-1:0] cur_wall_r;
  logic [CELL_W-1:0] nb_r [3];
  logic [1:0]        dir_r;
  logic [WALL_W-1:0] nxt_wall_r;
  logic [CELL_W-1:0] rd_data_r;
  logic [2*CW-1:0]   stack_rd_r;
  out_item_t         out_data_r;

  // Combinational
  logic              cur_in_grid;
  logic [3:0]        nb_ok;
  logic [CW-1:0]     nb_row [4];
  logic [CW-1:0]     nb_col [4];
  logic [AW-1:0]     nb_addr [4];
  logic [CELL_W-1:0] nb_cell [4];
  logic [AW-1:0]     cur_addr;
  logic [3:0]        cand;
  logic [2:0]        n_cand;
  logic [1:0]        pick;
  logic [1:0]        sel;
  logic [1:0]        seen;
  logic [1:0]        opp;
  logic              has_cand;
  logic [WALL_W-1:0] cur_wall_new;
  logic [WALL_W-1:0] nb_wall_new;
  logic [DW-1:0]     depth_dec;
  logic              can_push;
  logic [CW-1:0]     pop_row, pop_col;
  logic              mem_we, mem_re, stk_we, stk_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  out_item_t         result;

  assign cur_addr  = cell_addr(cur_row_r, cur_col_r);
  assign depth_dec = depth_r - DW'(1);
  assign can_push  = depth_r < DW'(CELL_COUNT);
  assign {pop_row, pop_col} = stack_rd_r;

  // Neighbour positions and bounds
  always_comb begin
    cur_in_grid = (SIDE_W'(cur_row_r) < side_r) && (SIDE_W'(cur_col_r) < side_r);
    nb_row[DIR_UP]    = cur_row_r - CW'(1);
    nb_col[DIR_UP]    = cur_col_r;
    nb_row[DIR_RIGHT] = cur_row_r;
    nb_col[DIR_RIGHT] = cur_col_r + CW'(1);
    nb_row[DIR_DOWN]  = cur_row_r + CW'(1);
    nb_col[DIR_DOWN]  = cur_col_r;
    nb_row[DIR_LEFT]  = cur_row_r;
    nb_col[DIR_LEFT]  = cur_col_r - CW'(1);
    nb_ok[DIR_UP]     = cur_in_grid && (cur_row_r != '0);
    nb_ok[DIR_RIGHT]  = cur_in_grid && ((SIDE_W'(cur_col_r) + SIDE_W'(1)) < side_r);
    nb_ok[DIR_DOWN]   = cur_in_grid && ((SIDE_W'(cur_row_r) + SIDE_W'(1)) < side_r);
    nb_ok[DIR_LEFT]   = cur_in_grid && (cur_col_r != '0);
    for (int k = 0; k < 4; k++) begin
      // off-grid neighbours read the current cell; their data is masked
      nb_addr[k] = nb_ok[k] ? cell_addr(nb_row[k], nb_col[k]) : cur_addr;
    end
  end

  // Candidate selection; left neighbour data is still in the read register
  always_comb begin
    nb_cell[0] = nb_r[0];
    nb_cell[1] = nb_r[1];
    nb_cell[2] = nb_r[2];
    nb_cell[3] = rd_data_r;
    for (int k = 0; k < 4; k++) begin
      cand[k] = nb_ok[k] && !nb_cell[k][WALL_W];
    end
    n_cand   = 3'($countones(cand));
    has_cand = |cand;
    case (n_cand)
      3'd2:    pick = {1'b0, req_r.random_value[0]};
      3'd3:    pick = mod3_r;
      3'd4:    pick = req_r.random_value[1:0];
      default: pick = 2'd0;
    endcase
    sel  = 2'd0;
    seen = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand[k]) begin
        if (seen == pick) begin
          sel = 2'(k);
        end
        seen = seen + 2'd1;
      end
    end
    opp          = sel ^ 2'b10;
    cur_wall_new = cur_wall_r & ~(WALL_W'(1) << sel);
    nb_wall_new  = nb_cell[sel][WALL_W-1:0] & ~(WALL_W'(1) << opp);
  end

  // Memory port decode
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    mem_waddr = cur_addr;
    mem_raddr = cur_addr;
    mem_wdata = {1'b0, WALLS_ALL};
    unique case (cmd.act)
      ACT_CLR_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      ACT_RD_CUR: mem_re = 1'b1;
      ACT_RD_UP: begin
        mem_re    = 1'b1;
        mem_raddr = nb_addr[DIR_UP];
      end
      ACT_RD_RIGHT: begin
        mem_re    = 1'b1;
        mem_raddr = nb_addr[DIR_RIGHT];
      end
      ACT_RD_DOWN: begin
        mem_re    = 1'b1;
        mem_raddr = nb_addr[DIR_DOWN];
      end
      ACT_RD_LEFT: begin
        mem_re    = 1'b1;
        mem_raddr = nb_addr[DIR_LEFT];
      end
      ACT_RD_QUERY: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr(CW'(req_r.query_row), CW'(req_r.query_col));
      end
      ACT_DECIDE: begin
        // mark current visited, knock out its wall if moving
        mem_we    = 1'b1;
        mem_wdata = {1'b1, has_cand ? cur_wall_new : cur_wall_r};
        stk_we    = has_cand && can_push;
        stk_re    = !has_cand && (depth_r != '0);
      end
      ACT_WR_NEXT: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, nxt_wall_r};
      end
      ACT_POP: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr(pop_row, pop_col);
      end
      default: ;
    endcase
  end

  // Cell memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= cell_mem[mem_raddr];
    end
  end

  // Path stack, registered read
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[depth_r[AW-1:0]] <= {cur_row_r, cur_col_r};
    end
    if (stk_re) begin
      stack_rd_r <= stack_mem[depth_dec[AW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= SIDE_W'(SIDE_RST);
      act_q_r     <= ACT_NOP;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      depth_r     <= '0;
      finished_r  <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        side_r <= clamp_side(cfg_wdata);
      end
      act_q_r <= cmd.act;
      case (cmd.act)
        ACT_CLR_INIT: begin
          clr_cnt_r  <= '0;
          cur_row_r  <= '0;
          cur_col_r  <= '0;
          depth_r    <= '0;
          finished_r <= 1'b0;
        end
        ACT_CLR_STEP: clr_cnt_r <= clr_cnt_r + AW'(1);
        ACT_DECIDE: begin
          if (has_cand) begin
            cur_row_r <= nb_row[sel];
            cur_col_r <= nb_col[sel];
            if (can_push) begin
              depth_r <= depth_r + DW'(1);
            end
          end else if (depth_r != '0) begin
            depth_r <= depth_dec;
          end else begin
            finished_r <= 1'b1;
          end
        end
        ACT_POP: begin
          cur_row_r <= pop_row;
          cur_col_r <= pop_col;
        end
        default: ;
      endcase
      // output register
      if (cmd.act == ACT_PUBLISH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload captures
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_ACCEPT) begin
      req_r  <= in_data;
      mod3_r <= mod3_16(in_data.random_value);
    end
    case (act_q_r)
      ACT_RD_CUR:   cur_wall_r <= rd_data_r[WALL_W-1:0];
      ACT_RD_UP:    nb_r[0]    <= rd_data_r;
      ACT_RD_RIGHT: nb_r[1]    <= rd_data_r;
      ACT_RD_DOWN:  nb_r[2]    <= rd_data_r;
      default: ;
    endcase
    if (cmd.act == ACT_DECIDE) begin
      dir_r      <= sel;
      nxt_wall_r <= nb_wall_new;
    end
    if (cmd.act == ACT_PUBLISH) begin
      out_data_r <= result;
    end
  end

  // Reply assembly
  always_comb begin
    case (cmd.rep.lsel)
      LSEL_CUR: begin
        result.cell_col = COORD_W'(cur_col_r);
        result.cell_row = COORD_W'(cur_row_r);
      end
      LSEL_QUERY: begin
        result.cell_col = req_r.query_col;
        result.cell_row = req_r.query_row;
      end
      default: begin
        result.cell_col = '0;
        result.cell_row = '0;
      end
    endcase
    case (cmd.rep.wsel)
      WSEL_RD:   result.cell_walls = rd_data_r[WALL_W-1:0];
      WSEL_CUR:  result.cell_walls = cur_wall_r;
      WSEL_NEXT: result.cell_walls = nxt_wall_r;
      default:   result.cell_walls = WALLS_ALL;
    endcase
    result.step_kind       = cmd.rep.kind;
    result.carve_direction = (cmd.rep.kind == KIND_CARVED) ? dir_r : 2'd0;
  end

  // Status
  assign stat.op          = req_r.operation;
  assign stat.finished    = finished_r;
  assign stat.q_in_grid   = (32'(req_r.query_col) < 32'(side_r)) &&
                            (32'(req_r.query_row) < 32'(side_r));
  assign stat.has_cand    = has_cand;
  assign stat.stack_empty = (depth_r == '0);
  assign stat.clear_last  = (clr_cnt_r == AW'(CELL_COUNT - 1));
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/mbs_checker.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker step checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbs_checker import mbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Result transaction held while stalled
  `MBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `MBS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "result changed")

  // The input is closed in the cycle after an accepted transaction
  `MBS_ASSERT(a_in_busy, in_valid && in_ready |=> !in_ready, "input open after accept")

  // No result can appear in the cycle right after an acceptance
  `MBS_ASSERT(a_no_fast, in_valid && in_ready |=> !$rose(out_valid), "result too early")

  // Reset leaves both channels quiet while the clearing pass starts
  `MBS_ASSERT_NR(a_reset, !rst_n |=> !out_valid && !in_ready, "busy after reset")

endmodule

bind maze_backtracker_step_unit mbs_checker u_mbs_checker (.*);

// ===== sim/tb_maze_backtracker_step_unit.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker step unit testbench
// Drives carve, read, restart and ignored transactions over several grid
// sizes. Each accepted transaction is run through a local maze model. Every
// result is then compared field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module tb_maze_backtracker_step_unit;
  import mbs_pkg::*;

  localparam int SIDE_MAX    = DEF_MAX_SIDE;
  localparam int CELLS       = SIDE_MAX * SIDE_MAX;
  localparam int CLEAR_WAIT  = CELLS + 64;     // a restart may still be clearing
  localparam int STALL_LIMIT = 10000;
  localparam int PHASE_ITEMS = 155;
  localparam int SHOWN_MAX   = 10;

  // Pending stimulus: either a transaction or a grid_side write
  typedef struct {
    bit               is_cfg;
    bit               drain;
    logic [CFG_W-1:0] side;
    in_item_t         item;
  } job_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  job_t      job_q[$];
  out_item_t reply_q[$];
  int        mismatch_cnt = 0;
  int        stall_cycles = 0;

  maze_backtracker_step_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Maze model
  // --------------------------------------------------------------------------
  bit                seen      [CELLS];
  logic [WALL_W-1:0] walls_mem [CELLS];
  int                trail     [CELLS];
  int                trail_depth;
  int                here_cell;
  int                side_now;
  bit                done_flag;

  function automatic int clamp_side(int v);
    if (v < 2) return 2;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  function automatic void clear_maze();
    foreach (seen[i]) begin
      seen[i]      = 1'b0;
      walls_mem[i] = WALLS_ALL;
    end
    trail_depth = 0;
    here_cell   = 0;
    done_flag   = 1'b0;
  endfunction

  function automatic void set_side(logic [CFG_W-1:0] v);
    side_now = clamp_side(int'(v));
    clear_maze();
  endfunction

  function automatic out_item_t cell_reply(kind_t k, dir_t d);
    out_item_t r;
    r.cell_col        = COORD_W'(here_cell % SIDE_MAX);
    r.cell_row        = COORD_W'(here_cell / SIDE_MAX);
    r.step_kind       = k;
    r.carve_direction = d;
    r.cell_walls      = walls_mem[here_cell];
    return r;
  endfunction

  // Advance the model by one transaction and return the reply it gives
  function automatic out_item_t predict_step(in_item_t it);
    out_item_t r;
    int        row;
    int        col;
    int        n;
    int        pick;
    int        nxt;
    int        cand[4];
    dir_t      dirs[4];
    dir_t      d;
    bit        in_grid;
    case (op_t'(it.operation))
      OP_CARVE: begin
        if (done_flag) begin
          r = cell_reply(KIND_FINISHED, DIR_UP);
        end else begin
          seen[here_cell] = 1'b1;
          row     = here_cell / SIDE_MAX;
          col     = here_cell % SIDE_MAX;
          in_grid = (row < side_now) && (col < side_now);
          n       = 0;
          // unvisited neighbours, up / right / down / left
          if (in_grid && row > 0 && !seen[here_cell - SIDE_MAX]) begin
            cand[n] = here_cell - SIDE_MAX; dirs[n] = DIR_UP; n++;
          end
          if (in_grid && col + 1 < side_now && !seen[here_cell + 1]) begin
            cand[n] = here_cell + 1; dirs[n] = DIR_RIGHT; n++;
          end
          if (in_grid && row + 1 < side_now && !seen[here_cell + SIDE_MAX]) begin
            cand[n] = here_cell + SIDE_MAX; dirs[n] = DIR_DOWN; n++;
          end
          if (in_grid && col > 0 && !seen[here_cell - 1]) begin
            cand[n] = here_cell - 1; dirs[n] = DIR_LEFT; n++;
          end
          if (n > 0) begin
            pick = int'(it.random_value) % n;
            d    = dirs[pick];
            nxt  = cand[pick];
            // knock through the shared wall from both sides
            walls_mem[here_cell][d]            = 1'b0;
            walls_mem[nxt][(int'(d) + 2) % 4]  = 1'b0;
            if (trail_depth < CELLS) begin
              trail[trail_depth] = here_cell;
              trail_depth++;
            end
            here_cell = nxt;
            r = cell_reply(KIND_CARVED, d);
          end else if (trail_depth > 0) begin
            trail_depth--;
            here_cell = trail[trail_depth];
            r = cell_reply(KIND_BACK, DIR_UP);
          end else begin
            done_flag = 1'b1;
            r = cell_reply(KIND_FINISHED, DIR_UP);
          end
        end
      end
      OP_READ: begin
        r.cell_col        = it.query_col;
        r.cell_row        = it.query_row;
        r.step_kind       = KIND_REPLY;
        r.carve_direction = DIR_UP;
        if (int'(it.query_col) < side_now && int'(it.query_row) < side_now)
          r.cell_walls = walls_mem[int'(it.query_row) * SIDE_MAX + int'(it.query_col)];
        else
          r.cell_walls = WALLS_ALL;
      end
      OP_RESTART: begin
        clear_maze();
        r.cell_col        = '0;
        r.cell_row        = '0;
        r.step_kind       = KIND_REPLY;
        r.carve_direction = DIR_UP;
        r.cell_walls      = WALLS_ALL;
      end
      default: begin
        r = cell_reply(KIND_REPLY, DIR_UP);
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic in_item_t mk_item(op_t op, int rnd, int qc, int qr);
    in_item_t it;
    it.operation    = op;
    it.random_value = RAND_W'(rnd);
    it.query_col    = COORD_W'(qc);
    it.query_row    = COORD_W'(qr);
    return it;
  endfunction

  function automatic void add_item(in_item_t it, bit drain);
    job_t j;
    j.is_cfg = 1'b0;
    j.drain  = drain;
    j.side   = '0;
    j.item   = it;
    job_q.push_back(j);
  endfunction

  function automatic void add_cfg(int v);
    job_t j;
    j.is_cfg = 1'b1;
    j.drain  = 1'b1;
    j.side   = CFG_W'(v);
    j.item   = '0;
    job_q.push_back(j);
  endfunction

  // Mostly carve steps so that mazes run through to completion
  function automatic void add_random(int count, int side_set);
    int  eff;
    int  k;
    int  qc;
    int  qr;
    op_t op;
    eff = clamp_side(side_set);
    for (int i = 0; i < count; i++) begin
      k  = $urandom_range(0, 99);
      op = (k < 72) ? OP_CARVE : (k < 88) ? OP_READ : (k < 90) ? OP_RESTART : OP_IGNORE;
      if ($urandom_range(0, 1) == 0) begin
        qc = $urandom_range(0, eff - 1);
        qr = $urandom_range(0, eff - 1);
      end else begin
        qc = $urandom_range(0, 31);
        qr = $urandom_range(0, 31);
      end
      add_item(mk_item(op, $urandom_range(0, 65535), qc, qr),
               (i == count / 3) || ($urandom_range(0, 59) == 0));
    end
  endfunction

  initial begin
    int phase_side[10];
    int v;
    side_now = clamp_side(RESET_SIDE);
    clear_maze();

    // directed: full-size grid straight after reset
    add_item(mk_item(OP_READ, 0, 0, 0), 1'b0);
    add_item(mk_item(OP_READ, 16'hFFFF, 31, 31), 1'b0);
    add_item(mk_item(OP_IGNORE, 16'hFFFF, 31, 31), 1'b0);
    add_item(mk_item(OP_CARVE, 0, 0, 0), 1'b0);
    add_item(mk_item(OP_CARVE, 16'hFFFF, 0, 0), 1'b0);
    add_item(mk_item(OP_CARVE, 1, 0, 0), 1'b0);
    add_item(mk_item(OP_READ, 0, 1, 0), 1'b0);
    add_item(mk_item(OP_READ, 0, 0, 1), 1'b0);
    add_item(mk_item(OP_RESTART, 0, 0, 0), 1'b0);
    add_item(mk_item(OP_CARVE, 16'hAAAA, 0, 0), 1'b0);

    // directed: side below range saturates to 2; carve to the end and beyond
    add_cfg(0);
    for (int i = 0; i < 9; i++)
      add_item(mk_item(OP_CARVE, i, 0, 0), 1'b0);
    add_item(mk_item(OP_READ, 0, 1, 1), 1'b0);
    add_item(mk_item(OP_READ, 0, 2, 0), 1'b0);
    add_item(mk_item(OP_READ, 0, 0, 2), 1'b0);
    add_item(mk_item(OP_IGNORE, 0, 0, 0), 1'b0);
    add_item(mk_item(OP_RESTART, 16'hFFFF, 31, 31), 1'b0);

    // random phases, mostly small grids; -1 picks a random register value
    phase_side = '{3, 63, 5, 1, 8, 33, 2, -1, 4, 32};
    foreach (phase_side[p]) begin
      v = (phase_side[p] < 0) ? $urandom_range(0, 63) : phase_side[p];
      add_cfg(v);
      add_random(PHASE_ITEMS, v);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (job_q.size() != 0 || in_valid) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: input transactions and grid_side writes
  // --------------------------------------------------------------------------
  int               send_gap  = 0;
  bit               send_calm = 1'b0;
  int               quiet_cnt = 0;
  logic             nxt_valid;
  in_item_t         nxt_data;
  logic             nxt_we;
  logic [CFG_W-1:0] nxt_wdata;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      cfg_we    <= 1'b0;
      cfg_wdata <= '0;
      send_gap  = 0;
      quiet_cnt = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      nxt_we    = 1'b0;
      nxt_wdata = cfg_wdata;
      if (cfg_we)
        set_side(cfg_wdata);
      if (in_valid && in_ready) begin
        reply_q.push_back(predict_step(in_data));
        nxt_valid = 1'b0;
        if ($urandom_range(0, 39) == 0)
          send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 9);
      end
      quiet_cnt = (reply_q.size() == 0 && !in_valid) ? quiet_cnt + 1 : 0;
      // next transaction or register write once the channel is free
      if (!nxt_valid && !cfg_we) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (job_q.size() > 0) begin
          if (job_q[0].is_cfg) begin
            if (quiet_cnt >= CLEAR_WAIT) begin
              nxt_we    = 1'b1;
              nxt_wdata = job_q[0].side;
              void'(job_q.pop_front());
              quiet_cnt = 0;
            end
          end else if (!job_q[0].drain || reply_q.size() == 0) begin
            nxt_valid = 1'b1;
            nxt_data  = job_q[0].item;
            void'(job_q.pop_front());
          end
        end
      end
      in_valid  <= nxt_valid;
      in_data   <= nxt_data;
      cfg_we    <= nxt_we;
      cfg_wdata <= nxt_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: result transactions against predicted replies
  // --------------------------------------------------------------------------
  int        recv_gap  = 0;
  bit        recv_calm = 1'b0;
  logic      nxt_ready;
  out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  = 0;
    end else begin
      nxt_ready = out_ready;
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOWN_MAX)
            $display("unexpected result: col %0d row %0d kind %0d dir %0d walls %h",
                     out_data.cell_col, out_data.cell_row, out_data.step_kind,
                     out_data.carve_direction, out_data.cell_walls);
        end else begin
          want = reply_q.pop_front();
          if (want.cell_col !== out_data.cell_col || want.cell_row !== out_data.cell_row ||
              want.step_kind !== out_data.step_kind ||
              want.carve_direction !== out_data.carve_direction ||
              want.cell_walls !== out_data.cell_walls) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOWN_MAX)
              $display("result differs: exp col %0d row %0d kind %0d dir %0d walls %h, got col %0d row %0d kind %0d dir %0d walls %h",
                       want.cell_col, want.cell_row, want.step_kind,
                       want.carve_direction, want.cell_walls,
                       out_data.cell_col, out_data.cell_row, out_data.step_kind,
                       out_data.carve_direction, out_data.cell_walls);
          end
        end
        if ($urandom_range(0, 39) == 0)
          recv_calm = !recv_calm;
        recv_gap  = recv_calm ? 0 : $urandom_range(0, 9);
        nxt_ready = (recv_gap == 0);
      end else if (!out_ready) begin
        if (recv_gap > 0)
          recv_gap--;
        nxt_ready = (recv_gap == 0);
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
